// ===== hw/rtl/irq_latency_statistics_macros.svh =====
// Assertion macros used by the irq latency statistics checker.
`ifndef IRQ_LATENCY_STATISTICS_MACROS_SVH
`define IRQ_LATENCY_STATISTICS_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define ILS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define ILS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ils_pkg.sv =====
// Types, widths and codes of the irq latency statistics block.
package ils_pkg;

    localparam int NUM_LINES = 16;
    localparam int IDX_W     = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
    localparam int NZ_W      = $clog2(NUM_LINES + 1);

    localparam int LINE_W    = 4;
    localparam int LAT_W     = 32;
    localparam int CNT_W     = 32;
    localparam int SUM_W     = 64;
    localparam int PEAK_W    = 32;
    localparam int FRAC_W    = 8;
    localparam int MEAN_W    = 40;
    localparam int MSUM_W    = MEAN_W + NZ_W;

    localparam int DSOR_W    = CNT_W;
    localparam int QUOT_W    = MEAN_W;
    localparam int DEND_W    = QUOT_W + DSOR_W;
    localparam int DCNT_W    = $clog2(QUOT_W + 1);

    localparam int S_TDATA_W = ((LINE_W + LAT_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((LINE_W + CNT_W + MEAN_W + PEAK_W + 7) / 8) * 8;

    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_REPORT = 1'b1;

    typedef struct packed {
        logic [CNT_W-1:0]  count;
        logic [SUM_W-1:0]  sum;
        logic [PEAK_W-1:0] peak;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_LOAD,
        S_DIV,
        S_ROW,
        S_TLOAD,
        S_TDIV,
        S_TROW
    } t_state;

endpackage

// ===== hw/rtl/ils_div.sv =====
// Restoring divider, one quotient bit per cycle.
module ils_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [ils_pkg::DEND_W-1:0] i_dividend,
    input  logic [ils_pkg::DSOR_W-1:0] i_divisor,
    output logic                       o_busy,
    output logic [ils_pkg::QUOT_W-1:0] o_quot
);
    import ils_pkg::*;

    logic [DCNT_W-1:0] r_cnt;
    logic [DSOR_W-1:0] r_rem;
    logic [DSOR_W-1:0] r_dsor;
    logic [QUOT_W-1:0] r_acc;
    logic [DSOR_W:0]   trial;
    logic [DSOR_W:0]   diff;
    logic              ge;

    assign trial  = {r_rem, r_acc[QUOT_W-1]};
    assign diff   = trial - {1'b0, r_dsor};
    assign ge     = trial >= {1'b0, r_dsor};
    assign o_busy = r_cnt != '0;
    assign o_quot = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= DCNT_W'(QUOT_W);
        end else if (o_busy) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_dividend[DEND_W-1 -: DSOR_W];
            r_acc  <= i_dividend[QUOT_W-1:0];
            r_dsor <= i_divisor;
        end else if (o_busy) begin
            r_rem  <= ge ? diff[DSOR_W-1:0] : trial[DSOR_W-1:0];
            r_acc  <= {r_acc[QUOT_W-2:0], ge};
        end
    end

endmodule

// ===== hw/rtl/irq_latency_statistics.sv =====
// Per-line interrupt latency statistics: count, latency sum and peak per line, with reports.
// A sample request (tuser 0) updates its line's count, sum and peak through a read-modify-write
// of one on-chip table entry; samples are taken one per cycle while no report runs and give no
// output. A report request (tuser 1) stalls the input and emits NUM_LINES rows in line order
// and a total row marked by tuser and tlast. Each row with a nonzero count runs the shared
// bit-serial divider for the mean (40 quotient bits), a row with a zero count skips it, and
// the total row divides the sum of the row means by the number of lines with samples, skipping
// the divider when no line has samples; the input stays stalled until the total row is emitted.
// The table reads as zero after reset with no clearing pass; reports leave it unchanged.
module irq_latency_statistics (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [ils_pkg::S_TDATA_W-1:0] i_s_tdata,  // line_id, latency_value
    input  logic [0:0]                    i_s_tuser,  // action
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [ils_pkg::M_TDATA_W-1:0] o_m_tdata,  // row_line, occurrence_count,
                                                      // mean_latency, peak_latency
    output logic [0:0]                    o_m_tuser,  // is_total
    output logic                          o_m_tlast   // last_row
);
    import ils_pkg::*;

    t_state r_state, n_state;

    t_entry             r_mem [NUM_LINES];
    logic [NUM_LINES-1:0] r_valid;
    t_entry             r_rd_data;
    logic               r_rd_vld;
    logic [IDX_W-1:0]   rd_addr;

    logic               in_action;
    logic [LINE_W-1:0]  in_line;
    logic [LAT_W-1:0]   in_lat;
    logic               s_acc;
    logic               in_range;

    logic               r_s1_vld;
    logic [IDX_W-1:0]   r_s1_addr;
    logic [LAT_W-1:0]   r_s1_lat;
    logic               r_fwd_vld;
    logic [IDX_W-1:0]   r_fwd_addr;
    t_entry             r_fwd_data;
    t_entry             cur;
    t_entry             upd;

    logic [IDX_W-1:0]   r_k;
    logic [CNT_W-1:0]   r_row_cnt;
    logic [PEAK_W-1:0]  r_row_peak;
    logic [CNT_W-1:0]   r_tot_cnt;
    logic [PEAK_W-1:0]  r_tot_peak;
    logic [MSUM_W-1:0]  r_mean_sum;
    logic [NZ_W-1:0]    r_nz;
    t_entry             ld;
    logic [CNT_W:0]     tot_sum;
    logic [MEAN_W-1:0]  row_mean;
    logic [MEAN_W-1:0]  tot_mean;

    logic               div_start;
    logic [DEND_W-1:0]  div_dend;
    logic [DSOR_W-1:0]  div_dsor;
    logic               div_busy;
    logic [QUOT_W-1:0]  div_quot;

    logic               slot_free;
    logic               emit_row;
    logic               emit_tot;
    logic               rd_sel_k;
    logic               rpt_start;

    logic               r_out_vld;
    logic [LINE_W-1:0]  r_out_line;
    logic               r_out_total;
    logic [CNT_W-1:0]   r_out_cnt;
    logic [MEAN_W-1:0]  r_out_mean;
    logic [PEAK_W-1:0]  r_out_peak;

    assign in_action = i_s_tuser[0];
    assign in_line   = i_s_tdata[LINE_W-1:0];
    assign in_lat    = i_s_tdata[LINE_W +: LAT_W];
    assign s_acc     = i_s_tvalid && o_s_tready;
    assign in_range  = int'(in_line) < NUM_LINES;
    assign rpt_start = s_acc && (in_action == ACT_REPORT);
    assign slot_free = !r_out_vld || i_m_tready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (rpt_start) n_state = S_RD;
            S_RD:    n_state = S_LOAD;
            S_LOAD:  n_state = (ld.count != '0) ? S_DIV : S_ROW;
            S_DIV:   if (!div_busy) n_state = S_ROW;
            S_ROW: begin
                if (slot_free) begin
                    n_state = (r_k == IDX_W'(NUM_LINES - 1)) ? S_TLOAD : S_RD;
                end
            end
            S_TLOAD: n_state = (r_nz != '0) ? S_TDIV : S_TROW;
            S_TDIV:  if (!div_busy) n_state = S_TROW;
            S_TROW:  if (slot_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_s_tready = 1'b0;
        rd_sel_k   = 1'b0;
        div_start  = 1'b0;
        emit_row   = 1'b0;
        emit_tot   = 1'b0;
        unique case (r_state)
            S_IDLE:  o_s_tready = 1'b1;
            S_RD:    rd_sel_k   = 1'b1;
            S_LOAD:  div_start  = ld.count != '0;
            S_DIV:   ;
            S_ROW:   emit_row   = slot_free;
            S_TLOAD: div_start  = r_nz != '0;
            S_TDIV:  ;
            S_TROW:  emit_tot   = slot_free;
            default: ;
        endcase
    end

    // table read port and sample write port
    assign rd_addr = rd_sel_k ? r_k : IDX_W'(in_line);

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[rd_addr];
        if (r_s1_vld) begin
            r_mem[r_s1_addr] <= upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= r_valid[rd_addr];
            if (r_s1_vld) begin
                r_valid[r_s1_addr] <= 1'b1;
            end
        end
    end

    // sample update with forwarding of the previous write
    always_comb begin
        if (r_fwd_vld && (r_fwd_addr == r_s1_addr)) begin
            cur = r_fwd_data;
        end else if (r_rd_vld) begin
            cur = r_rd_data;
        end else begin
            cur = '0;
        end
        upd = cur;
        if (cur.count != '1) begin
            upd.count = cur.count + 1'b1;
            upd.sum   = cur.sum + SUM_W'(r_s1_lat);
        end
        if (r_s1_lat > cur.peak) begin
            upd.peak = r_s1_lat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_fwd_vld <= 1'b0;
        end else begin
            r_s1_vld  <= s_acc && (in_action == ACT_SAMPLE) && in_range;
            r_fwd_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_addr  <= IDX_W'(in_line);
        r_s1_lat   <= in_lat;
        r_fwd_addr <= r_s1_addr;
        r_fwd_data <= upd;
    end

    // report sequencing
    assign ld       = r_rd_vld ? r_rd_data : '0;
    assign div_dend = (r_state == S_LOAD) ? {ld.sum, FRAC_W'(0)} : DEND_W'(r_mean_sum);
    assign div_dsor = (r_state == S_LOAD) ? ld.count : DSOR_W'(r_nz);
    assign row_mean = (r_row_cnt != '0) ? div_quot : '0;
    assign tot_mean = (r_nz != '0) ? div_quot : '0;
    assign tot_sum  = {1'b0, r_tot_cnt} + {1'b0, r_row_cnt};

    ils_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dend),
        .i_divisor  (div_dsor),
        .o_busy     (div_busy),
        .o_quot     (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rpt_start) begin
            r_k        <= '0;
            r_tot_cnt  <= '0;
            r_tot_peak <= '0;
            r_mean_sum <= '0;
            r_nz       <= '0;
        end
        if (r_state == S_LOAD) begin
            r_row_cnt  <= ld.count;
            r_row_peak <= ld.peak;
        end
        if (emit_row) begin
            r_k        <= r_k + 1'b1;
            r_tot_cnt  <= tot_sum[CNT_W] ? '1 : tot_sum[CNT_W-1:0];
            r_mean_sum <= r_mean_sum + MSUM_W'(row_mean);
            if (r_row_cnt != '0) begin
                r_nz <= r_nz + 1'b1;
            end
            if (r_row_peak > r_tot_peak) begin
                r_tot_peak <= r_row_peak;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (emit_row || emit_tot) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_row) begin
            r_out_line  <= LINE_W'(r_k);
            r_out_total <= 1'b0;
            r_out_cnt   <= r_row_cnt;
            r_out_mean  <= row_mean;
            r_out_peak  <= r_row_peak;
        end else if (emit_tot) begin
            r_out_line  <= '0;
            r_out_total <= 1'b1;
            r_out_cnt   <= r_tot_cnt;
            r_out_mean  <= tot_mean;
            r_out_peak  <= r_tot_peak;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = M_TDATA_W'({r_out_peak, r_out_mean, r_out_cnt, r_out_line});
    assign o_m_tuser  = r_out_total;
    assign o_m_tlast  = r_out_total;

endmodule

// ===== hw/rtl/ils_checker.sv =====
// Port-level checks of the irq latency statistics block and their binding.
`include "irq_latency_statistics_macros.svh"

module ils_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_tvalid,
    input logic                          o_s_tready,
    input logic [0:0]                    i_s_tuser,  // action
    input logic                          o_m_tvalid,
    input logic                          i_m_tready,
    input logic [ils_pkg::M_TDATA_W-1:0] o_m_tdata,  // row_line, occurrence_count,
                                                     // mean_latency, peak_latency
    input logic [0:0]                    o_m_tuser,  // is_total
    input logic                          o_m_tlast   // last_row
);
    import ils_pkg::*;

    `ILS_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready,
                     o_m_tvalid && $stable(o_m_tdata), "output row changed while stalled")
    `ILS_ASSERT_SAME(a_last_is_total, o_m_tvalid, o_m_tlast == o_m_tuser[0],
                     "last row and total row disagree")
    `ILS_ASSERT_SAME(a_total_line_zero, o_m_tvalid && o_m_tuser[0],
                     o_m_tdata[LINE_W-1:0] == '0, "total row carries a line index")
    `ILS_ASSERT_NEXT(a_report_stalls, i_s_tvalid && o_s_tready && i_s_tuser[0],
                     !o_s_tready, "input taken right after a report request")
    `ILS_ASSERT_SAME(a_rows_block_input, o_m_tvalid && !o_m_tlast, !o_s_tready,
                     "input ready during a report")

endmodule

bind irq_latency_statistics ils_checker u_ils_checker (.*);
